// ===== rtl/wpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpd_pkg
// Types, codes and constants shared by the WAV parser and downmix block.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int unsigned SUM_W = 24;              // frame sum width
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [15:0] CHAN_RST = 16'd1;
  localparam logic [15:0] BITS_RST = 16'd8;
  localparam logic [31:0] RATE_RST = 32'd22050;

  typedef enum logic [3:0] {
    PH_RIFF = 4'd0,
    PH_SIZE = 4'd1,
    PH_WAVE = 4'd2,
    PH_HEAD = 4'd3,
    PH_FMT  = 4'd4,
    PH_SKIP = 4'd5,
    PH_PAD  = 4'd6,
    PH_DATA = 4'd7,
    PH_IDLE = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NOT_RIFF  = 4'd0,
    ERR_NOT_WAVE  = 4'd1,
    ERR_FMT_SHORT = 4'd2,
    ERR_NOT_PCM   = 4'd3,
    ERR_NO_FMT    = 4'd4,
    ERR_NO_DATA   = 4'd5,
    ERR_EMPTY     = 4'd6,
    ERR_BAD_BITS  = 4'd7,
    ERR_MANY_CH   = 4'd8
  } err_e;

  typedef enum logic [1:0] {
    CT_READY = 2'd0,
    CT_DIV   = 2'd1,
    CT_OUT0  = 2'd2,
    CT_OUT1  = 2'd3
  } ctl_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  smp;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [15:0] bits;
    err_e        err;
    logic        last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic take;
    logic div_start;
    logic sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] nres;
    logic       div_req;
    logic       div_done;
    logic       two_q;
  } sts_t;

  function automatic logic [7:0] riff_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h52;
      2'd1: r = 8'h49;
      2'd2: r = 8'h46;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] wave_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h57;
      2'd1: r = 8'h41;
      2'd2: r = 8'h56;
      default: r = 8'h45;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/wpd_in_if.sv =====
// ----------------------------------------------------------------------------
// wpd_in_if
// Byte stream channel into the WAV parser.
// ----------------------------------------------------------------------------
interface wpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, file_byte, end_of_file, input ready);
  modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

// ===== rtl/wpd_out_if.sv =====
// ----------------------------------------------------------------------------
// wpd_out_if
// Result channel out of the WAV parser.
// ----------------------------------------------------------------------------
interface wpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  sample_out;
  logic [31:0] rate_hz;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [3:0]  error_code;
  logic        run_last;

  modport source (output valid, kind, sample_out, rate_hz, channel_count, sample_bits,
                  error_code, run_last, input ready);
  modport sink (input valid, kind, sample_out, rate_hz, channel_count, sample_bits,
                error_code, run_last, output ready);
endinterface

// ===== rtl/wav_parse_and_pcm_downmix.sv =====
// ----------------------------------------------------------------------------
// wav_parse_and_pcm_downmix
// RIFF/WAVE byte parser with mono 8-bit PCM downmix.
// ----------------------------------------------------------------------------
// Sequence: a byte's results are registered when the byte is taken. A byte
//   that completes a frame waits on the bit-serial divider (24 quotient bits)
//   before the sample is shown.
// Throughput: one byte per cycle when it causes no result; while results are
//   handed out or a frame is divided, no new byte is taken.
// Reset: asynchronous, active low; the parser expects the RIFF tag.
module wav_parse_and_pcm_downmix import wpd_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpd_in_if.sink    in_i,
  wpd_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;
  logic out_valid;

  wpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .out_valid_o (out_valid)
  );

  wpd_dpath #(.MAX_CHANNELS(MAX_CHANNELS)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .file_byte_i     (in_i.file_byte),
    .end_of_file_i   (in_i.end_of_file),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_o          (out_o.kind),
    .sample_out_o    (out_o.sample_out),
    .rate_hz_o       (out_o.rate_hz),
    .channel_count_o (out_o.channel_count),
    .sample_bits_o   (out_o.sample_bits),
    .error_code_o    (out_o.error_code),
    .run_last_o      (out_o.run_last)
  );

  assign in_i.ready  = cmd.in_ready;
  assign out_o.valid = out_valid;

endmodule

// ===== rtl/wpd_div.sv =====
// ----------------------------------------------------------------------------
// wpd_div
// Restoring divider, one quotient bit per cycle: frame sum magnitude by
// channel count.
// ----------------------------------------------------------------------------
module wpd_div import wpd_pkg::*; #(
  parameter int unsigned DW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quot_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [DW:0]      rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic             done_q, done_d;
  logic [DW:0]      trial;
  logic [DW+1:0]    diff;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], quo_q[SUM_W-1]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (!diff[DW+1]) begin
        rem_d = diff[DW:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy after done");

endmodule

// ===== rtl/wpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer: takes a byte, waits for its downmix divide if any, then hands out
// the one or two results of that byte.
// ----------------------------------------------------------------------------
module wpd_ctrl import wpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic out_valid_o
);

  ctl_e st_q, st_d;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      CT_READY: begin
        if (in_valid_i && sts_i.nres != 2'd0) begin
          st_d = sts_i.div_req ? CT_DIV : CT_OUT0;
        end
      end
      CT_DIV: begin
        if (sts_i.div_done) st_d = CT_OUT0;
      end
      CT_OUT0: begin
        if (out_ready_i) st_d = sts_i.two_q ? CT_OUT1 : CT_READY;
      end
      CT_OUT1: begin
        if (out_ready_i) st_d = CT_READY;
      end
      default: st_d = CT_READY;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    out_valid_o     = 1'b0;
    unique case (st_q)
      CT_READY: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.take      = in_valid_i;
        cmd_o.div_start = in_valid_i && sts_i.div_req;
      end
      CT_OUT0: begin
        out_valid_o = 1'b1;
      end
      CT_OUT1: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CT_READY;
    end else begin
      st_q <= st_d;
    end
  end

  a_div_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> st_q == CT_DIV) else $error("divide not waited for");
  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q == CT_OUT1) |-> $past(st_q == CT_OUT0 && out_ready_i))
    else $error("second result without first transfer");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> st_q == CT_DIV) else $error("divide done out of sequence");

endmodule

// ===== rtl/wpd_dpath.sv =====
// ----------------------------------------------------------------------------
// wpd_dpath
// Parse state, chunk walking, fmt capture, frame accumulation and the
// result registers.
// ----------------------------------------------------------------------------
module wpd_dpath import wpd_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  sample_out_o,
  output logic [31:0] rate_hz_o,
  output logic [15:0] channel_count_o,
  output logic [15:0] sample_bits_o,
  output logic [3:0]  error_code_o,
  output logic        run_last_o
);

  localparam int unsigned DW = $clog2(MAX_CHANNELS + 1);

  phase_e                   ph_q, ph_d;
  logic [31:0]              pos_q, pos_d;
  logic [31:0]              len_q, len_d;
  logic [31:0]              tag_q, tag_d;
  logic                     pad_q, pad_d;
  logic                     fmt_q, fmt_d;
  logic [15:0]              chan_q, chan_d;
  logic [15:0]              bits_q, bits_d;
  logic [31:0]              rate_q, rate_d;
  logic [31:0]              rem_q, rem_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [DW-1:0]            cidx_q, cidx_d;
  logic [7:0]               low_q, low_d;

  res_t             res_a [2];
  res_t             res_q [2];
  logic [1:0]       n;
  logic             div_req;
  logic [SUM_W-1:0] div_mag;
  logic             div_neg;
  logic             neg_q;
  logic             is8_q;
  logic             two_q;
  logic [DW-1:0]    chv;
  logic [31:0]      pos_inc;
  logic signed [SUM_W-1:0] sum_t;
  logic             have;
  logic             div_done;
  logic [SUM_W-1:0] quot;
  logic [7:0]       smp8;
  logic [7:0]       hi8;
  res_t             blank;
  res_t             r;

  assign pos_inc = pos_q + 32'd1;
  assign chv     = (chan_q == 16'd0) ? DW'(1) : chan_q[DW-1:0];

  always_comb begin
    ph_d    = ph_q;
    pos_d   = pos_q;
    len_d   = len_q;
    tag_d   = tag_q;
    pad_d   = pad_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    bits_d  = bits_q;
    rate_d  = rate_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    cidx_d  = cidx_q;
    low_d   = low_q;
    n       = 2'd0;
    div_req = 1'b0;
    div_mag = '0;
    div_neg = 1'b0;
    sum_t   = sum_q;
    have    = 1'b0;
    blank   = '{kind: KIND_HEADER, smp: 8'd0, rate: 32'd0, chans: 16'd0, bits: 16'd0,
                err: ERR_NOT_RIFF, last: 1'b0};
    r       = blank;
    res_a[0] = blank;
    res_a[1] = blank;

    unique case (ph_q)
      PH_RIFF: begin
        if (file_byte_i != riff_byte(pos_q[1:0])) begin
          r.kind = KIND_ERROR; r.err = ERR_NOT_RIFF;
          res_a[n[0]] = r; n = n + 2'd1; ph_d = PH_IDLE;
        end else if (pos_inc == 32'd4) begin
          pos_d = '0; ph_d = PH_SIZE;
        end else begin
          pos_d = pos_inc;
        end
      end
      PH_SIZE: begin
        if (pos_inc == 32'd4) begin
          pos_d = '0; ph_d = PH_WAVE;
        end else begin
          pos_d = pos_inc;
        end
      end
      PH_WAVE: begin
        if (file_byte_i != wave_byte(pos_q[1:0])) begin
          r.kind = KIND_ERROR; r.err = ERR_NOT_WAVE;
          res_a[n[0]] = r; n = n + 2'd1; ph_d = PH_IDLE;
        end else if (pos_inc == 32'd4) begin
          pos_d = '0; ph_d = PH_HEAD;
        end else begin
          pos_d = pos_inc;
        end
      end
      PH_HEAD: begin
        if (pos_q[31:2] == 30'd0) begin
          tag_d = {tag_q[23:0], file_byte_i};
          if (pos_q[1:0] == 2'd3) len_d = '0;
        end else begin
          unique case (pos_q[1:0])
            2'd0: len_d[7:0]   = len_q[7:0]   | file_byte_i;
            2'd1: len_d[15:8]  = len_q[15:8]  | file_byte_i;
            2'd2: len_d[23:16] = len_q[23:16] | file_byte_i;
            default: len_d[31:24] = len_q[31:24] | file_byte_i;
          endcase
        end
        pos_d = pos_inc;
        if (pos_inc == 32'd8) begin
          pos_d = '0;
          pad_d = len_d[0];
          if (tag_d == TAG_FMT) begin
            if (len_d < 32'd16) begin
              r.kind = KIND_ERROR; r.err = ERR_FMT_SHORT;
              res_a[n[0]] = r; n = n + 2'd1; ph_d = PH_IDLE;
            end else begin
              ph_d = PH_FMT;
            end
          end else if (tag_d == TAG_DATA) begin
            r.kind = KIND_ERROR;
            priority if (!fmt_q) begin
              r.err = ERR_NO_FMT;
            end else if (len_d == 32'd0) begin
              r.err = ERR_EMPTY;
            end else if (bits_q != 16'd8 && bits_q != 16'd16) begin
              r.err = ERR_BAD_BITS;
            end else if (chan_q > 16'(MAX_CHANNELS)) begin
              r.err = ERR_MANY_CH;
            end else begin
              r.kind  = KIND_HEADER;
              r.err   = ERR_NOT_RIFF;
              r.rate  = rate_q;
              r.chans = chan_q;
              r.bits  = bits_q;
            end
            res_a[n[0]] = r; n = n + 2'd1;
            if (r.kind == KIND_HEADER) begin
              rem_d  = len_d;
              sum_d  = '0;
              cidx_d = '0;
              ph_d   = PH_DATA;
            end else begin
              ph_d = PH_IDLE;
            end
          end else if (len_d == 32'd0) begin
            ph_d = PH_HEAD;
          end else begin
            ph_d = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (pos_q == 32'd1 && {file_byte_i, low_q} != 16'd1) begin
          r.kind = KIND_ERROR; r.err = ERR_NOT_PCM;
          res_a[n[0]] = r; n = n + 2'd1; ph_d = PH_IDLE;
        end else begin
          if (pos_q == 32'd0) low_d = file_byte_i;
          if (pos_q == 32'd2) chan_d[7:0] = file_byte_i;
          if (pos_q == 32'd3) chan_d[15:8] = file_byte_i;
          if (pos_q[31:2] == 30'd1) begin
            unique case (pos_q[1:0])
              2'd0: rate_d[7:0]   = file_byte_i;
              2'd1: rate_d[15:8]  = file_byte_i;
              2'd2: rate_d[23:16] = file_byte_i;
              default: rate_d[31:24] = file_byte_i;
            endcase
          end
          if (pos_q == 32'd14) bits_d[7:0] = file_byte_i;
          if (pos_q == 32'd15) begin
            bits_d[15:8] = file_byte_i;
            fmt_d        = 1'b1;
          end
          pos_d = pos_inc;
          if (pos_inc == len_q) begin
            pos_d = '0;
            ph_d  = pad_q ? PH_PAD : PH_HEAD;
          end
        end
      end
      PH_SKIP: begin
        pos_d = pos_inc;
        if (pos_inc == len_q) begin
          pos_d = '0;
          ph_d  = pad_q ? PH_PAD : PH_HEAD;
        end
      end
      PH_PAD: begin
        pos_d = '0;
        ph_d  = PH_HEAD;
      end
      PH_DATA: begin
        rem_d = rem_q - 32'd1;
        if (bits_q == 16'd8) begin
          sum_t = sum_q + SUM_W'({1'b0, file_byte_i});
          have  = 1'b1;
        end else if (!pos_q[0]) begin
          low_d = file_byte_i;
        end else begin
          sum_t = sum_q + {{(SUM_W-16){file_byte_i[7]}}, file_byte_i, low_q};
          have  = 1'b1;
        end
        sum_d    = sum_t;
        pos_d[0] = ~pos_q[0];
        if (have) begin
          cidx_d = cidx_q + DW'(1);
          if (cidx_d >= chv) begin
            // frame complete: divide the magnitude, sign restored later
            div_req = 1'b1;
            div_neg = sum_t[SUM_W-1];
            div_mag = div_neg ? SUM_W'(-sum_t) : SUM_W'(sum_t);
            r.kind  = KIND_SAMPLE;
            res_a[n[0]] = r; n = n + 2'd1;
            r       = blank;
            sum_d   = '0;
            cidx_d  = '0;
          end
        end
        if (rem_d == 32'd0) begin
          r.kind = KIND_DONE;
          res_a[n[0]] = r; n = n + 2'd1; ph_d = PH_IDLE;
        end
      end
      default: ;
    endcase

    if (end_of_file_i) begin
      r = blank;
      if (n == 2'd0 || ph_d != PH_IDLE) begin
        priority if (ph_d == PH_DATA) begin
          r.kind = KIND_DONE;
        end else if (ph_d == PH_RIFF) begin
          r.kind = KIND_ERROR; r.err = ERR_NOT_RIFF;
        end else if (ph_d == PH_SIZE || ph_d == PH_WAVE) begin
          r.kind = KIND_ERROR; r.err = ERR_NOT_WAVE;
        end else if (ph_d != PH_IDLE) begin
          r.kind = KIND_ERROR; r.err = fmt_d ? ERR_NO_DATA : ERR_NO_FMT;
        end
        if (ph_d != PH_IDLE) begin
          res_a[n[0]] = r; n = n + 2'd1;
        end
      end
      // restart from reset after the final byte
      ph_d   = PH_RIFF;
      pos_d  = '0;
      len_d  = '0;
      tag_d  = '0;
      pad_d  = 1'b0;
      fmt_d  = 1'b0;
      chan_d = CHAN_RST;
      bits_d = BITS_RST;
      rate_d = RATE_RST;
      rem_d  = '0;
      sum_d  = '0;
      cidx_d = '0;
      low_d  = '0;
    end

    if (n == 2'd1) res_a[0].last = 1'b1;
    if (n == 2'd2) res_a[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_RIFF;
      pos_q  <= '0;
      len_q  <= '0;
      tag_q  <= '0;
      pad_q  <= 1'b0;
      fmt_q  <= 1'b0;
      chan_q <= CHAN_RST;
      bits_q <= BITS_RST;
      rate_q <= RATE_RST;
      rem_q  <= '0;
      sum_q  <= '0;
      cidx_q <= '0;
      low_q  <= '0;
      two_q  <= 1'b0;
    end else if (cmd_i.take) begin
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      tag_q  <= tag_d;
      pad_q  <= pad_d;
      fmt_q  <= fmt_d;
      chan_q <= chan_d;
      bits_q <= bits_d;
      rate_q <= rate_d;
      rem_q  <= rem_d;
      sum_q  <= sum_d;
      cidx_q <= cidx_d;
      low_q  <= low_d;
      two_q  <= (n == 2'd2);
    end
  end

  wpd_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_mag),
    .divisor_i  (chv),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // 16-bit: avg/256 truncated toward zero, then offset by 128
  assign hi8  = neg_q ? (8'd0 - quot[15:8]) : quot[15:8];
  assign smp8 = is8_q ? quot[7:0] : (hi8 + 8'd128);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_q[0] <= res_a[0];
      res_q[1] <= res_a[1];
      neg_q    <= div_neg;
      is8_q    <= (bits_q == 16'd8);
    end else if (div_done) begin
      res_q[0].smp <= smp8;
    end
  end

  assign sts_o.nres     = n;
  assign sts_o.div_req  = div_req;
  assign sts_o.div_done = div_done;
  assign sts_o.two_q    = two_q;

  assign kind_o          = res_q[cmd_i.sel].kind;
  assign sample_out_o    = res_q[cmd_i.sel].smp;
  assign rate_hz_o       = res_q[cmd_i.sel].rate;
  assign channel_count_o = res_q[cmd_i.sel].chans;
  assign sample_bits_o   = res_q[cmd_i.sel].bits;
  assign error_code_o    = res_q[cmd_i.sel].err;
  assign run_last_o      = res_q[cmd_i.sel].last;

  a_cidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_DATA |-> cidx_q < chv) else $error("channel index past frame");
  a_data_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_DATA |-> chan_q <= 16'(MAX_CHANNELS)) else $error("too many channels");
  a_div_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> res_q[0].kind == KIND_SAMPLE) else $error("divide without sample");

endmodule
